// ===== rtl/eot_pkg.sv =====
// ----------------------------------------------------------------------------
// eot_pkg
// Shared types, codes and helpers of the edge orientation tally unit.
// ----------------------------------------------------------------------------
package eot_pkg;

  localparam int CNT_W       = 10;
  localparam int IDX_W       = 10;
  localparam int TYPE_W      = 3;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int BOOT_W      = 10;
  localparam int THRESH_W    = 11;
  localparam int PROD_W      = BOOT_W + THRESH_W;
  localparam int CONS_W      = 3;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 56;
  localparam int NUM_PAIRS_DEF = 1024;

  localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;

  localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  localparam logic [TYPE_W-1:0] ET_NONE       = 3'd0;
  localparam logic [TYPE_W-1:0] ET_DIRECTED   = 3'd1;
  localparam logic [TYPE_W-1:0] ET_UNDIRECTED = 3'd2;
  localparam logic [TYPE_W-1:0] ET_BIDIRECTED = 3'd3;
  localparam logic [TYPE_W-1:0] ET_PARTIAL_I  = 3'd4;
  localparam logic [TYPE_W-1:0] ET_PARTIAL_J  = 3'd5;
  localparam logic [TYPE_W-1:0] ET_NONDIR     = 3'd6;

  localparam logic [CONS_W-1:0] CONS_NONE = 3'd0;
  localparam logic [CONS_W-1:0] CONS_UV   = 3'd1;
  localparam logic [CONS_W-1:0] CONS_VU   = 3'd2;
  localparam logic [CONS_W-1:0] CONS_BI   = 3'd3;
  localparam logic [CONS_W-1:0] CONS_UN   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BOOT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STAB_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_THRESH  = 2'd2;

  localparam logic [BOOT_W-1:0]   BOOT_RESET   = 10'd100;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 11'd717;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    cnt_t bi;
    cnt_t un;
    cnt_t vu;
    cnt_t uv;
    cnt_t app;
  } tally_t;

  localparam int TALLY_W = $bits(tally_t);

  typedef struct packed {
    logic [CONS_W-1:0] consensus;
    logic              stable;
    tally_t            tally;
  } result_t;

  function automatic cnt_t sat_inc(input cnt_t c);
    cnt_t r;
    r = (c == CNT_MAX) ? c : c + 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/edge_orientation_tally_unit.sv =====
// ----------------------------------------------------------------------------
// edge_orientation_tally_unit
// Table of per-pair edge orientation tallies with record, query and clear.
// ----------------------------------------------------------------------------
// Items enter on the in_ stream (mode, pair index, edge type) and every item
// gives exactly one result item on the out_ stream: the five counters of the
// pair, the stability flag and the consensus orientation.
// The tallies live in one RAM with a registered read. A record or
// query item reads its entry on acceptance; in the update state, once the
// output register is free, an in-range record item writes the updated
// entry back while the output register and out_tvalid are loaded.
// A new item is accepted only after the last one has left the update
// state, as the single RAM is read, modified and written back per item.
// A clear item sweeps the RAM one entry per cycle and then reports an
// all-zero result. After reset the same sweep clears the table while
// in_tready stays low; configuration writes are taken at any time.
// When the receiver stalls, the finished result waits in the output
// register and one further item is still accepted and read; its update is
// held until the output register is free.
// ----------------------------------------------------------------------------
module edge_orientation_tally_unit #(
  parameter int NUM_PAIRS = eot_pkg::NUM_PAIRS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // [1:0] mode, [11:2] pair_index, [14:12] edge_type, [15] zero
  input  logic [eot_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [9:0] appearances, [19:10] count_u_to_v, [29:20] count_v_to_u,
  // [39:30] count_undirected, [49:40] count_bidirected, [50] stable flag,
  // [53:51] consensus, [55:54] zero
  output logic [eot_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [eot_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [eot_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import eot_pkg::*;

  localparam int AW = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
  localparam int RANGE_W = 17;

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_CLR  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [MODE_W-1:0]   mode_r;
  logic [TYPE_W-1:0]   et_r;
  logic [AW-1:0]       addr_r;
  logic                oor_r;
  logic [BOOT_W-1:0]   boot_r;
  logic [THRESH_W-1:0] stab_r;
  logic [THRESH_W-1:0] ext_r;
  logic [PROD_W-1:0]   stab_prod_r;
  logic [PROD_W-1:0]   ext_prod_r;
  logic                out_valid_r, out_valid_nxt;
  result_t             out_res_r;

  logic [MODE_W-1:0]   in_mode;
  logic [IDX_W-1:0]    in_idx;
  logic [TYPE_W-1:0]   in_et;
  logic [AW+IDX_W-1:0] idx_ext;
  logic [AW-1:0]       in_addr;
  logic                in_oor;
  logic                accept;
  logic                slot_free;
  logic                clr_last;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  tally_t              ram_wdata;
  tally_t              ram_rdata;
  tally_t              upd_tally;
  result_t             upd_res;
  result_t             res_sel;

  assign in_mode = in_tdata[1:0];
  assign in_idx  = in_tdata[11:2];
  assign in_et   = in_tdata[14:12];
  assign idx_ext = {{AW{1'b0}}, in_idx};
  assign in_addr = idx_ext[AW-1:0];
  assign in_oor  = (RANGE_W'(in_idx) >= RANGE_W'(NUM_PAIRS));

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign clr_last  = (clr_cnt_r == AW'(NUM_PAIRS - 1));

  eot_ram #(
    .W     (TALLY_W),
    .DEPTH (NUM_PAIRS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  eot_update u_update (
    .cur       (ram_rdata),
    .record    (mode_r == MODE_RECORD),
    .edge_type (et_r),
    .stab_prod (stab_prod_r),
    .ext_prod  (ext_prod_r),
    .nxt       (upd_tally),
    .res       (upd_res)
  );

  always_comb begin
    if ((state_r == S_INIT) || (state_r == S_CLR)) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_r == S_UPD) && slot_free && (mode_r == MODE_RECORD) && !oor_r;
      ram_waddr = addr_r;
      ram_wdata = upd_tally;
    end
  end

  assign res_sel = ((mode_r == MODE_CLEAR) || oor_r) ? '0 : upd_res;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_INIT: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_last) begin
          clr_cnt_nxt = '0;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_mode == MODE_CLEAR) ? S_CLR : S_UPD;
        end
      end
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_last) begin
          clr_cnt_nxt = '0;
          state_nxt   = S_UPD;
        end
      end
      S_UPD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      boot_r      <= BOOT_RESET;
      stab_r      <= THRESH_RESET;
      ext_r       <= THRESH_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_NUM_BOOT:    boot_r <= cfg_wdata[BOOT_W-1:0];
          CFG_STAB_THRESH: stab_r <= cfg_wdata;
          CFG_EXT_THRESH:  ext_r  <= cfg_wdata;
          default:         boot_r <= boot_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    stab_prod_r <= stab_r * boot_r;
    ext_prod_r  <= ext_r * boot_r;
    if (accept) begin
      mode_r <= in_mode;
      et_r   <= in_et;
      addr_r <= in_addr;
      oor_r  <= in_oor;
    end
    if ((state_r == S_UPD) && slot_free) begin
      out_res_r <= res_sel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

endmodule

// ===== rtl/eot_ram.sv =====
// ----------------------------------------------------------------------------
// eot_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module eot_ram #(
  parameter int  W     = 50,
  parameter int  DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/eot_update.sv =====
// ----------------------------------------------------------------------------
// eot_update
// Applies one observed edge type to a tally entry when record is set, and
// derives the stability flag and consensus orientation of the updated entry.
// ----------------------------------------------------------------------------
module eot_update (
  input  eot_pkg::tally_t                  cur,
  input  logic                             record,
  input  logic [eot_pkg::TYPE_W-1:0]       edge_type,
  input  logic [eot_pkg::PROD_W-1:0]       stab_prod,
  input  logic [eot_pkg::PROD_W-1:0]       ext_prod,
  output eot_pkg::tally_t                  nxt,
  output eot_pkg::result_t                 res
);
  import eot_pkg::*;

  logic [PROD_W-1:0] app_scaled;
  logic              uv_top;
  logic              vu_top;
  logic              bi_top;

  always_comb begin
    nxt = cur;
    if (record && (edge_type != ET_NONE)) begin
      nxt.app = sat_inc(cur.app);
      case (edge_type)
        ET_DIRECTED, ET_PARTIAL_I: nxt.uv = sat_inc(cur.uv);
        ET_PARTIAL_J:              nxt.vu = sat_inc(cur.vu);
        ET_UNDIRECTED, ET_NONDIR:  nxt.un = sat_inc(cur.un);
        ET_BIDIRECTED:             nxt.bi = sat_inc(cur.bi);
        default:                   nxt.app = sat_inc(cur.app);
      endcase
    end
  end

  assign app_scaled = {1'b0, nxt.app, 10'b0};

  assign uv_top = (nxt.uv >= nxt.vu) && (nxt.uv >= nxt.un) && (nxt.uv >= nxt.bi)
                  && (nxt.uv != '0);
  assign vu_top = (nxt.vu >= nxt.uv) && (nxt.vu >= nxt.un) && (nxt.vu >= nxt.bi)
                  && (nxt.vu != '0);
  assign bi_top = (nxt.bi >= nxt.uv) && (nxt.bi >= nxt.vu) && (nxt.bi >= nxt.un)
                  && (nxt.bi != '0);

  always_comb begin
    res.tally  = nxt;
    res.stable = (app_scaled >= stab_prod);
    if (app_scaled < ext_prod) begin
      res.consensus = CONS_NONE;
    end else if (uv_top) begin
      res.consensus = CONS_UV;
    end else if (vu_top) begin
      res.consensus = CONS_VU;
    end else if (bi_top) begin
      res.consensus = CONS_BI;
    end else if (nxt.un != '0) begin
      res.consensus = CONS_UN;
    end else begin
      res.consensus = CONS_NONE;
    end
  end

endmodule

// ===== rtl/eot_checker.sv =====
// ----------------------------------------------------------------------------
// eot_checker
// Port-level checks of the edge orientation tally unit, bound to the top.
// ----------------------------------------------------------------------------
module eot_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [eot_pkg::OUT_DATA_W-1:0] out_tdata
);
  import eot_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while previous item still at work");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[19:10] <= out_tdata[9:0]) &&
                    (out_tdata[49:40] <= out_tdata[9:0])))
    else $error("orientation count exceeds appearances");

  a_consensus_uv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[53:51] == CONS_UV)) |-> (out_tdata[19:10] != 10'd0))
    else $error("u-to-v consensus with zero u-to-v count");

endmodule

bind edge_orientation_tally_unit eot_checker u_eot_checker (.*);
